### hdl/naive_substring_search_unit_defines.svh
// assertion macros for the substring search unit
// expects clk and rst_n in the scope where the macros are used
`ifndef NAIVE_SUBSTRING_SEARCH_UNIT_DEFINES_SVH
`define NAIVE_SUBSTRING_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NSS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nss_pkg.sv
// shared types and constants for the substring search unit
// no dependencies
`default_nettype none

package nss_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 12;
  localparam int CMP_W  = 20;

  typedef enum logic [1:0] {
    OP_LOAD_PATTERN = 2'd0,
    OP_LOAD_TEXT    = 2'd1,
    OP_SEARCH       = 2'd2,
    OP_CLEAR        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### hdl/nss_if.sv
// valid/ready channels for the substring search unit
// depends on nss_pkg
`default_nettype none

interface nss_in_if;
  import nss_pkg::*;

  logic             valid;
  logic             ready;
  op_t              opcode;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface nss_out_if;
  import nss_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] match_position;
  logic [CMP_W-1:0] comparison_count;
  logic             overflow;

  modport source (output valid, output found, output match_position,
                  output comparison_count, output overflow, input ready);
  modport sink   (input valid, input found, input match_position,
                  input comparison_count, input overflow, output ready);
endinterface

`default_nettype wire

### hdl/nss_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module nss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/naive_substring_search_unit.sv
// top level of the brute-force substring search unit
// depends on nss_pkg, nss_if, nss_ram and naive_substring_search_unit_defines.svh
`default_nettype none

// Load and clear words are accepted back to back. A search word runs one byte comparison
// per cycle out of the pattern and text rams (each has one read port, and the next read
// address follows from the byte compare of the current cycle), then posts its result from
// the done state once the output register is free; an empty or too-long pattern goes
// straight to the done state with no comparison. While a search runs no word is
// accepted; a waiting result does not hold up loads or clears.
module naive_substring_search_unit #(
  parameter int TEXT_DEPTH    = 4096,
  parameter int PATTERN_DEPTH = 256
) (
  input wire logic  clk,
  input wire logic  rst_n,
  nss_in_if.sink    in_ch,
  nss_out_if.source out_ch
);
  import nss_pkg::*;

  `include "naive_substring_search_unit_defines.svh"

  localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int TCW = $clog2(TEXT_DEPTH + 1);
  localparam int PCW = $clog2(PATTERN_DEPTH + 1);
  localparam int CW  = (TCW > PCW) ? TCW : PCW;

  state_t state_r, state_nxt;

  logic [PCW-1:0]   pat_cnt_r, pat_cnt_nxt;
  logic [TCW-1:0]   txt_cnt_r, txt_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [PCW-1:0]   p_r, p_nxt;
  logic [TCW-1:0]   t_r, t_nxt;
  logic [TCW-1:0]   start_r, start_nxt;
  logic [TCW-1:0]   last_start_r, last_start_nxt;
  logic [CMP_W-1:0] cmp_r, cmp_nxt;
  logic             found_r, found_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [CMP_W-1:0] out_cmp_r, out_cmp_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic              in_fire;
  logic              search_go;
  logic              trivial;
  logic              pat_we, txt_we;
  logic              rd_en;
  logic [PAW-1:0]    pat_raddr;
  logic [TAW-1:0]    txt_raddr;
  logic [BYTE_W-1:0] pat_byte, txt_byte;
  logic              byte_eq;
  logic [PCW-1:0]    p_inc;
  logic              hit_end, miss_end, search_end;
  logic              out_load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign search_go   = in_fire && (in_ch.opcode == OP_SEARCH);
  assign trivial     = (CW'(pat_cnt_r) > CW'(txt_cnt_r)) || (pat_cnt_r == '0);

  assign pat_we = in_fire && (in_ch.opcode == OP_LOAD_PATTERN)
                  && (pat_cnt_r < PCW'(PATTERN_DEPTH));
  assign txt_we = in_fire && (in_ch.opcode == OP_LOAD_TEXT)
                  && (txt_cnt_r < TCW'(TEXT_DEPTH));

  assign byte_eq    = (pat_byte == txt_byte);
  assign p_inc      = p_r + PCW'(1);
  assign hit_end    = byte_eq && (p_inc == pat_cnt_r);
  assign miss_end   = !byte_eq && (start_r == last_start_r);
  assign search_end = hit_end || miss_end;
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  nss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PATTERN_DEPTH)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_cnt_r[PAW-1:0]),
    .wdata (in_ch.data_byte),
    .re    (rd_en),
    .raddr (pat_raddr),
    .rdata (pat_byte)
  );

  nss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TEXT_DEPTH)
  ) u_txt_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (txt_cnt_r[TAW-1:0]),
    .wdata (in_ch.data_byte),
    .re    (rd_en),
    .raddr (txt_raddr),
    .rdata (txt_byte)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (search_go) begin
          state_nxt = trivial ? ST_DONE : ST_CMP;
        end
      end
      ST_CMP: begin
        if (search_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pat_cnt_nxt    = pat_cnt_r;
    txt_cnt_nxt    = txt_cnt_r;
    ovf_nxt        = ovf_r;
    p_nxt          = p_r;
    t_nxt          = t_r;
    start_nxt      = start_r;
    last_start_nxt = last_start_r;
    cmp_nxt        = cmp_r;
    found_nxt      = found_r;
    rd_en          = 1'b0;
    pat_raddr      = '0;
    txt_raddr      = '0;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    out_cmp_nxt    = out_cmp_r;
    out_ovf_nxt    = out_ovf_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.opcode)
            OP_LOAD_PATTERN: begin
              if (pat_we) begin
                pat_cnt_nxt = pat_cnt_r + PCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_LOAD_TEXT: begin
              if (txt_we) begin
                txt_cnt_nxt = txt_cnt_r + TCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_CLEAR: begin
              pat_cnt_nxt = '0;
              txt_cnt_nxt = '0;
              ovf_nxt     = 1'b0;
            end
            OP_SEARCH: begin
              p_nxt          = '0;
              t_nxt          = '0;
              start_nxt      = '0;
              cmp_nxt        = '0;
              last_start_nxt = txt_cnt_r - TCW'(pat_cnt_r);
              found_nxt      = (pat_cnt_r == '0);
              rd_en          = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        if (cmp_r != '1) begin
          cmp_nxt = cmp_r + CMP_W'(1);
        end
        rd_en = !search_end;
        if (byte_eq) begin
          p_nxt     = p_inc;
          t_nxt     = t_r + TCW'(1);
          found_nxt = hit_end;
        end else begin
          p_nxt     = '0;
          t_nxt     = start_r + TCW'(1);
          start_nxt = start_r + TCW'(1);
          found_nxt = 1'b0;
        end
        pat_raddr = p_nxt[PAW-1:0];
        txt_raddr = t_nxt[TAW-1:0];
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_pos_nxt   = found_r ? POS_W'(start_r) : '0;
          out_cmp_nxt   = cmp_r;
          out_ovf_nxt   = ovf_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pat_cnt_r   <= '0;
      txt_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pat_cnt_r   <= pat_cnt_nxt;
      txt_cnt_r   <= txt_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    t_r          <= t_nxt;
    start_r      <= start_nxt;
    last_start_r <= last_start_nxt;
    cmp_r        <= cmp_nxt;
    found_r      <= found_nxt;
    out_found_r  <= out_found_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cmp_r    <= out_cmp_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.found            = out_found_r;
  assign out_ch.match_position   = out_pos_r;
  assign out_ch.comparison_count = out_cmp_r;
  assign out_ch.overflow         = out_ovf_r;

  `NSS_ASSERT_IMPLIES(a_p_below_len, state_r == ST_CMP, p_r < pat_cnt_r, "pattern index at or past length")
  `NSS_ASSERT_IMPLIES(a_start_in_range, state_r == ST_CMP, start_r <= last_start_r, "start past last start")
  `NSS_ASSERT_IMPLIES(a_t_tracks, state_r == ST_CMP, 32'(t_r) == 32'(start_r) + 32'(p_r), "text index off start")
  `NSS_ASSERT_NEXT(a_search_busy, search_go, state_r != ST_IDLE, "search did not leave idle")

endmodule

`default_nettype wire
